// ===== src/dfo_pkg.sv =====
package dfo_pkg;

	localparam int ROW_W      = 16;
	localparam int VERT_W     = 4;
	localparam int COUNT_W    = 5;
	localparam int LANE_W     = 4;
	localparam int LANES      = ROW_W / LANE_W;
	localparam int LANE_IDX_W = $clog2(LANE_W);

	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STEP,
		ST_POPRD,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic                  found;
		logic [LANE_IDX_W-1:0] idx;
	} lane_res_t;

	typedef struct packed {
		logic              found;
		logic [VERT_W-1:0] vertex;
	} merge_res_t;

	typedef struct packed {
		logic lane_en;
		logic push;
		logic pop;
		logic pop_rd;
		logic top_load;
		logic flush;
	} walk_ctl_t;

endpackage

// ===== src/dfo_if.sv =====
interface dfo_row_if;
	logic                           valid;
	logic                           ready;
	logic [dfo_pkg::VERT_W-1:0]     row_index;
	logic [dfo_pkg::ROW_W-1:0]      row_bits;
	logic                           last_row;

	modport source (output valid, row_index, row_bits, last_row, input ready);
	modport sink (input valid, row_index, row_bits, last_row, output ready);
endinterface

interface dfo_visit_if;
	logic                           valid;
	logic                           ready;
	logic [dfo_pkg::VERT_W-1:0]     vertex;
	logic                           last_visit;
	logic                           empty_graph;

	modport source (output valid, vertex, last_visit, empty_graph, input ready);
	modport sink (input valid, vertex, last_visit, empty_graph, output ready);
endinterface

interface dfo_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dfo_pkg::COUNT_W-1:0]    vertex_count;

	modport source (output valid, vertex_count, input ready);
	modport sink (input valid, vertex_count, output ready);
endinterface

// ===== src/dfo_lane.sv =====
module dfo_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [dfo_pkg::LANE_W-1:0]       cand,
	output dfo_pkg::lane_res_t               res_s1
);

	dfo_pkg::lane_res_t res;

	always_comb begin
		res.found = 1'b0;
		res.idx   = '0;
		for (int i = dfo_pkg::LANE_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				res.found = 1'b1;
				res.idx   = dfo_pkg::LANE_IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else if (en) begin
			res_s1 <= res;
		end
	end

endmodule

// ===== src/dfo_merge.sv =====
module dfo_merge (
	input  dfo_pkg::lane_res_t  lane_res [dfo_pkg::LANES],
	output dfo_pkg::merge_res_t res
);

	always_comb begin
		res.found  = 1'b0;
		res.vertex = '0;
		for (int l = dfo_pkg::LANES - 1; l >= 0; l--) begin
			if (lane_res[l].found) begin
				res.found  = 1'b1;
				res.vertex = dfo_pkg::VERT_W'(l * dfo_pkg::LANE_W + int'(lane_res[l].idx));
			end
		end
	end

endmodule

// ===== src/dfo_stack.sv =====
module dfo_stack #(
	parameter int VERTICES = 16
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(VERTICES)-1:0]    wr_addr,
	input  logic [dfo_pkg::VERT_W-1:0]     wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(VERTICES)-1:0]    rd_addr,
	output logic [dfo_pkg::VERT_W-1:0]     rd_data_q
);

	logic [dfo_pkg::VERT_W-1:0] mem [VERTICES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// ===== src/stack_depth_first_order_unit.sv =====
// channel  | dir | payload                               | beat taken when
// cfg      | in  | vertex_count                          | cfg.valid & cfg.ready
// rows     | in  | row_index, row_bits, last_row         | rows.valid & rows.ready
// visits   | out | vertex, last_visit, empty_graph       | visits.valid & visits.ready
// Rows are accepted only while no walk runs. After the last row each step of the walk
// scans the lanes into registers and merges them; a found vertex is pushed, else the stack
// is popped and the new top read from stack memory; the final pop flushes the last visit.
// Each visit is held one step so its last flag is known; visits.ready low stalls the walk.
// arst_n clears control state and the visited mask and sets the count register to 16.
module stack_depth_first_order_unit #(
	parameter int VERTICES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	dfo_cfg_if.sink             cfg,
	dfo_row_if.sink             rows,
	dfo_visit_if.source         visits
);

	localparam int ADJ_ROWS = (VERTICES < dfo_pkg::ROW_W) ? VERTICES : dfo_pkg::ROW_W;
	localparam int AW       = $clog2(ADJ_ROWS);
	localparam int SAW      = $clog2(VERTICES);
	localparam int DW       = $clog2(VERTICES + 1);

	dfo_pkg::state_t state_q, state_d;
	dfo_pkg::walk_ctl_t ctl;

	logic [dfo_pkg::COUNT_W-1:0] vertex_count_q;
	logic [dfo_pkg::COUNT_W-1:0] n_eff;
	logic [dfo_pkg::ROW_W-1:0]   adj_q [ADJ_ROWS];
	logic [dfo_pkg::ROW_W-1:0]   visited_q;
	logic [dfo_pkg::ROW_W-1:0]   count_mask;
	logic [dfo_pkg::ROW_W-1:0]   cand;
	logic [DW-1:0]               depth_q;
	logic [DW-1:0]               depth_m2;
	logic [dfo_pkg::VERT_W-1:0]  top_q;
	logic [dfo_pkg::VERT_W-1:0]  pend_q;
	logic                        err_q;
	logic                        out_valid_q;
	logic [dfo_pkg::VERT_W-1:0]  out_vertex_q;
	logic                        out_last_q;
	logic                        out_err_q;
	logic                        out_free;
	logic                        row_beat;
	logic                        start;
	logic                        stack_wr_en;
	logic [SAW-1:0]              stack_wr_addr;
	logic [dfo_pkg::VERT_W-1:0]  stack_wr_data;
	logic [dfo_pkg::VERT_W-1:0]  stack_rd_data;

	dfo_pkg::lane_res_t  lane_res [dfo_pkg::LANES];
	dfo_pkg::merge_res_t merge_res;

	assign cfg.ready  = 1'b1;
	assign rows.ready = (state_q == dfo_pkg::ST_IDLE);
	assign row_beat   = rows.valid & rows.ready;
	assign start      = row_beat & rows.last_row;
	assign out_free   = !out_valid_q || visits.ready;

	assign visits.valid       = out_valid_q;
	assign visits.vertex      = out_vertex_q;
	assign visits.last_visit  = out_last_q;
	assign visits.empty_graph = out_err_q;

	assign n_eff = (int'(vertex_count_q) > ADJ_ROWS) ? dfo_pkg::COUNT_W'(ADJ_ROWS)
		: vertex_count_q;

	always_comb begin
		for (int j = 0; j < dfo_pkg::ROW_W; j++) begin
			count_mask[j] = (dfo_pkg::COUNT_W'(j) < n_eff);
		end
	end

	assign cand     = adj_q[top_q[AW-1:0]] & ~visited_q & count_mask;
	assign depth_m2 = depth_q - DW'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= dfo_pkg::COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			vertex_count_q <= cfg.vertex_count;
		end
	end

	always_ff @(posedge clk) begin
		if (row_beat && int'(rows.row_index) < ADJ_ROWS) begin
			adj_q[rows.row_index[AW-1:0]] <= rows.row_bits;
		end
	end

	genvar g;
	generate
		for (g = 0; g < dfo_pkg::LANES; g++) begin : g_lane
			dfo_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (ctl.lane_en),
				.cand   (cand[g*dfo_pkg::LANE_W +: dfo_pkg::LANE_W]),
				.res_s1 (lane_res[g])
			);
		end
	endgenerate

	dfo_merge u_merge (
		.lane_res (lane_res),
		.res      (merge_res)
	);

	assign stack_wr_en   = start || ctl.push;
	assign stack_wr_addr = start ? '0 : depth_q[SAW-1:0];
	assign stack_wr_data = start ? '0 : merge_res.vertex;

	dfo_stack #(
		.VERTICES (VERTICES)
	) u_stack (
		.clk       (clk),
		.wr_en     (stack_wr_en),
		.wr_addr   (stack_wr_addr),
		.wr_data   (stack_wr_data),
		.rd_en     (ctl.pop_rd),
		.rd_addr   (depth_m2[SAW-1:0]),
		.rd_data_q (stack_rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dfo_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (n_eff == '0) ? dfo_pkg::ST_FLUSH : dfo_pkg::ST_SCAN;
				end
			end
			dfo_pkg::ST_SCAN: begin
				state_d = dfo_pkg::ST_STEP;
			end
			dfo_pkg::ST_STEP: begin
				if (merge_res.found) begin
					if (out_free) begin
						state_d = dfo_pkg::ST_SCAN;
					end
				end else if (depth_q <= DW'(1)) begin
					state_d = dfo_pkg::ST_FLUSH;
				end else begin
					state_d = dfo_pkg::ST_POPRD;
				end
			end
			dfo_pkg::ST_POPRD: begin
				state_d = dfo_pkg::ST_SCAN;
			end
			dfo_pkg::ST_FLUSH: begin
				if (out_free) begin
					state_d = dfo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dfo_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			dfo_pkg::ST_IDLE: begin
			end
			dfo_pkg::ST_SCAN: begin
				ctl.lane_en = 1'b1;
			end
			dfo_pkg::ST_STEP: begin
				if (merge_res.found) begin
					ctl.push = out_free && (int'(depth_q) < VERTICES);
				end else begin
					ctl.pop    = 1'b1;
					ctl.pop_rd = (depth_q > DW'(1));
				end
			end
			dfo_pkg::ST_POPRD: begin
				ctl.top_load = 1'b1;
			end
			dfo_pkg::ST_FLUSH: begin
				ctl.flush = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dfo_pkg::ST_IDLE;
			visited_q   <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start && n_eff != '0) begin
				visited_q <= dfo_pkg::ROW_W'(1);
				depth_q   <= DW'(1);
			end else if (state_q == dfo_pkg::ST_STEP) begin
				if (merge_res.found && out_free) begin
					visited_q[merge_res.vertex] <= 1'b1;
				end
				if (ctl.push) begin
					depth_q <= depth_q + DW'(1);
				end else if (ctl.pop) begin
					depth_q <= depth_q - DW'(1);
				end
			end
			if (state_q == dfo_pkg::ST_STEP && merge_res.found && out_free) begin
				out_valid_q <= 1'b1;
			end else if (ctl.flush) begin
				out_valid_q <= 1'b1;
			end else if (visits.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			top_q  <= '0;
			pend_q <= '0;
			err_q  <= (n_eff == '0);
		end else if (ctl.top_load) begin
			top_q <= stack_rd_data;
		end else if (state_q == dfo_pkg::ST_STEP && merge_res.found && out_free) begin
			pend_q <= merge_res.vertex;
			if (ctl.push) begin
				top_q <= merge_res.vertex;
			end
		end
		if (state_q == dfo_pkg::ST_STEP && merge_res.found && out_free) begin
			out_vertex_q <= pend_q;
			out_last_q   <= 1'b0;
			out_err_q    <= 1'b0;
		end else if (ctl.flush) begin
			out_vertex_q <= pend_q;
			out_last_q   <= 1'b1;
			out_err_q    <= err_q;
		end
	end

endmodule

// ===== test/dfo_order_checker.sv =====
module dfo_order_checker (
	input  logic      clk,
	input  logic      arst_n,
	dfo_cfg_if        cfg,
	dfo_row_if        rows,
	dfo_visit_if      visits,
	output int        errors,
	output int        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [dfo_pkg::VERT_W-1:0] vertex;
		logic                       last_visit;
		logic                       empty_graph;
	} visit_t;

	logic [dfo_pkg::ROW_W-1:0]   adj_rows [16];
	logic [dfo_pkg::COUNT_W-1:0] vcount;
	visit_t                      order_q [$];
	visit_t                      got;
	visit_t                      want;

	task automatic queue_walk_order();
		int                        n;
		int                        depth;
		int                        cnt;
		bit                        pushed;
		logic [dfo_pkg::ROW_W-1:0] seen;
		logic [3:0]                stack [16];
		logic [3:0]                top;
		visit_t                    seq [16];
		n = (vcount > 5'd16) ? 16 : int'(vcount);
		if (n == 0) begin
			order_q.push_back('{vertex: '0, last_visit: 1'b1, empty_graph: 1'b1});
			return;
		end
		seen = 16'h0001;
		stack[0] = '0;
		depth = 1;
		seq[0] = '{vertex: '0, last_visit: 1'b0, empty_graph: 1'b0};
		cnt = 1;
		while (depth > 0) begin
			top = stack[depth-1];
			pushed = 1'b0;
			for (int j = 0; j < n; j++) begin
				if (adj_rows[top][j] && !seen[j]) begin
					stack[depth] = j[3:0];
					depth++;
					seen[j] = 1'b1;
					seq[cnt] = '{vertex: j[3:0], last_visit: 1'b0, empty_graph: 1'b0};
					cnt++;
					pushed = 1'b1;
					break;
				end
			end
			if (!pushed)
				depth--;
		end
		seq[cnt-1].last_visit = 1'b1;
		for (int i = 0; i < cnt; i++)
			order_q.push_back(seq[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount = dfo_pkg::COUNT_RESET;
			order_q.delete();
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				vcount = cfg.vertex_count;
			if (rows.valid && rows.ready) begin
				adj_rows[rows.row_index] = rows.row_bits;
				if (rows.last_row)
					queue_walk_order();
			end
			if (visits.valid && visits.ready) begin
				got = '{vertex: visits.vertex, last_visit: visits.last_visit,
					empty_graph: visits.empty_graph};
				if (order_q.size() == 0) begin
					errors++;
					$display("%0t: visit beat with none due: vertex %0d last %0b empty %0b",
						$time, got.vertex, got.last_visit, got.empty_graph);
				end else begin
					want = order_q.pop_front();
					if (got.vertex !== want.vertex) begin
						errors++;
						$display("%0t: vertex expected %0d actual %0d",
							$time, want.vertex, got.vertex);
					end
					if (got.last_visit !== want.last_visit) begin
						errors++;
						$display("%0t: last_visit expected %0b actual %0b",
							$time, want.last_visit, got.last_visit);
					end
					if (got.empty_graph !== want.empty_graph) begin
						errors++;
						$display("%0t: empty_graph expected %0b actual %0b",
							$time, want.empty_graph, got.empty_graph);
					end
				end
			end
			outstanding = order_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROW_ITEMS    = 410;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   visits_due;
	int   idle_max;
	int   rows_sent;
	bit   long_hold;

	dfo_cfg_if   cfg_ch ();
	dfo_row_if   row_ch ();
	dfo_visit_if visit_ch ();

	stack_depth_first_order_unit #(.VERTICES(16)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.rows   (row_ch),
		.visits (visit_ch)
	);

	dfo_order_checker CHK (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.rows        (row_ch),
		.visits      (visit_ch),
		.errors      (fail_count),
		.outstanding (visits_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_row(input logic [dfo_pkg::VERT_W-1:0] idx,
		input logic [dfo_pkg::ROW_W-1:0] bits, input logic last);
		int gap;
		gap = $urandom_range(idle_max, 0);
		if (gap > 0) begin
			row_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_ch.valid     = 1'b1;
		row_ch.row_index = idx;
		row_ch.row_bits  = bits;
		row_ch.last_row  = last;
		@(posedge clk);
		while (!row_ch.ready)
			@(posedge clk);
		@(negedge clk);
		rows_sent++;
	endtask

	task automatic set_count(input logic [dfo_pkg::COUNT_W-1:0] n);
		row_ch.valid = 1'b0;
		while (visits_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_ch.vertex_count = n;
		cfg_ch.valid        = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// chain 0 -> 1 -> ... -> 15 with back edges to 0; last row fans out to all
	task automatic send_chain();
		for (int i = 0; i < 15; i++)
			send_row(i[dfo_pkg::VERT_W-1:0], (16'h0001 << (i + 1)) | 16'h0001, 1'b0);
		send_row(4'd15, 16'hFFFF, 1'b1);
	endtask

	initial begin
		int w;
		visit_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				visit_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end
			w = $urandom_range(idle_max, 0);
			if (w > 0) begin
				visit_ch.ready = 1'b0;
				repeat (w) @(negedge clk);
			end
			visit_ch.ready = 1'b1;
			@(posedge clk);
			while (!(visit_ch.valid && visit_ch.ready))
				@(posedge clk);
		end
	end

	initial begin
		int                          nrows;
		bit                          hold_done;
		logic [dfo_pkg::ROW_W-1:0]   bits;
		logic [dfo_pkg::COUNT_W-1:0] n;
		arst_n              = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.vertex_count = '0;
		row_ch.valid        = 1'b0;
		row_ch.row_index    = '0;
		row_ch.row_bits     = '0;
		row_ch.last_row     = 1'b0;
		idle_max            = 0;
		rows_sent           = 0;
		long_hold           = 1'b0;
		hold_done           = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_chain();
		set_count(5'd5);
		send_row(4'd0, 16'hFFFF, 1'b1);
		set_count(5'd0);
		send_row(4'd3, 16'h0000, 1'b1);
		set_count(5'd1);
		send_row(4'd0, 16'hFFFF, 1'b1);
		set_count(5'd31);
		send_row(4'd0, 16'h0000, 1'b1);
		send_row(4'd0, 16'h8000, 1'b1);

		while (rows_sent < ROW_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       idle_max = 0;
				1:       idle_max = 16;
				default: idle_max = $urandom_range(1, 16);
			endcase
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 5))
					0:       n = 5'd0;
					1:       n = 5'd1;
					2:       n = 5'd16;
					3:       n = 5'd31;
					default: n = dfo_pkg::COUNT_W'($urandom_range(0, 31));
				endcase
				set_count(n);
			end
			if (!hold_done && rows_sent > 200) begin
				set_count(5'd16);
				long_hold = 1'b1;
				send_chain();
				repeat (4) send_row(dfo_pkg::VERT_W'($urandom_range(0, 15)),
					dfo_pkg::ROW_W'($urandom), 1'b0);
				hold_done = 1'b1;
			end else begin
				nrows = $urandom_range(1, 6);
				for (int r = 0; r < nrows; r++) begin
					case ($urandom_range(0, 5))
						0:       bits = dfo_pkg::ROW_W'($urandom & $urandom & $urandom);
						1:       bits = dfo_pkg::ROW_W'($urandom | $urandom);
						2:       bits = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
						default: bits = dfo_pkg::ROW_W'($urandom & $urandom);
					endcase
					send_row(dfo_pkg::VERT_W'($urandom_range(0, 15)), bits,
						(r == nrows - 1) && ($urandom_range(0, 7) != 0));
				end
			end
		end

		row_ch.valid = 1'b0;
		while (visits_due != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
